### rtl/wsd_pkg.sv
// Shared types and constants of the websocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  localparam logic [1:0] KindText  = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindPong  = 2'd2;
  localparam logic [1:0] KindClose = 2'd3;

  localparam logic [3:0] OpcText  = 4'h1;
  localparam logic [3:0] OpcClose = 4'h8;
  localparam logic [3:0] OpcPing  = 4'h9;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [7:0] PongHdr   = 8'h8A;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

### rtl/wsd_parser.sv
// Frame header parser and payload unmasker, one byte per transfer.
// Depends on wsd_pkg; yields up to two results per byte.
module wsd_parser import wsd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,
  input  logic [7:0]   byte_i,
  output result_pair_t res_o
);

  localparam logic [2:0] PhHdr0   = 3'd0;
  localparam logic [2:0] PhHdr1   = 3'd1;
  localparam logic [2:0] PhExt    = 3'd2;
  localparam logic [2:0] PhMask   = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;
  localparam logic [2:0] PhClosed = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  mpos_q, mpos_d;

  logic        go_len, go_pay, empty, last;
  logic [7:0]  key_byte, plain;
  result_pair_t res;

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    len_d    = len_q;
    hcnt_d   = hcnt_q;
    key_d    = key_q;
    mpos_d   = mpos_q;
    go_len   = 1'b0;
    go_pay   = 1'b0;
    empty    = 1'b0;
    last     = 1'b0;
    res      = '0;
    unique case (mpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    plain = byte_i ^ (mask_q ? key_byte : 8'h00);

    unique case (phase_q)
      PhClosed: begin
      end
      PhHdr1: begin
        mask_d = byte_i[7];
        len_d  = '0;
        if (byte_i[6:0] == Len16Code) begin
          hcnt_d  = 3'd1;
          phase_d = PhExt;
        end else if (byte_i[6:0] == Len64Code) begin
          hcnt_d  = 3'd7;
          phase_d = PhExt;
        end else begin
          len_d  = {57'd0, byte_i[6:0]};
          go_len = 1'b1;
        end
      end
      PhExt: begin
        len_d = {len_q[55:0], byte_i};
        if (hcnt_q == 3'd0) go_len = 1'b1;
        else hcnt_d = hcnt_q - 3'd1;
      end
      PhMask: begin
        key_d = {key_q[23:0], byte_i};
        if (hcnt_q == 3'd0) go_pay = 1'b1;
        else hcnt_d = hcnt_q - 3'd1;
      end
      PhData: begin
        mpos_d = mpos_q + 2'd1;
        len_d  = len_q - 64'd1;
        last   = (len_d == 64'd0);
        if (opcode_q == OpcText) begin
          res.count = 2'd1;
          res.res0  = '{kind: KindText, data: plain, last: last};
        end else if (opcode_q == OpcPing) begin
          res.count = 2'd1;
          res.res0  = '{kind: KindPong, data: plain, last: last};
        end
        if (last) begin
          if (opcode_q == OpcClose) begin
            res.count = 2'd1;
            res.res0  = '{kind: KindClose, data: 8'h00, last: 1'b1};
            phase_d   = PhClosed;
          end else begin
            phase_d = PhHdr0;
          end
        end
      end
      default: begin
        opcode_d = byte_i[3:0];
        phase_d  = PhHdr1;
      end
    endcase

    if (go_len) begin
      if (mask_d) begin
        key_d   = '0;
        hcnt_d  = 3'd3;
        phase_d = PhMask;
      end else begin
        go_pay = 1'b1;
      end
    end

    if (go_pay) begin
      empty   = (len_d == 64'd0);
      mpos_d  = 2'd0;
      phase_d = empty ? PhHdr0 : PhData;
      if (opcode_q == OpcPing) begin
        res.count = 2'd2;
        res.res0  = '{kind: KindPong, data: PongHdr, last: 1'b0};
        res.res1  = '{kind: KindPong, data: {1'b0, len_d[6:0]}, last: empty};
      end else if (empty && opcode_q == OpcText) begin
        res.count = 2'd1;
        res.res0  = '{kind: KindEmpty, data: 8'h00, last: 1'b1};
      end else if (empty && opcode_q == OpcClose) begin
        res.count = 2'd1;
        res.res0  = '{kind: KindClose, data: 8'h00, last: 1'b1};
        phase_d   = PhClosed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      hcnt_q   <= '0;
      key_q    <= '0;
      mpos_q   <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      hcnt_q   <= hcnt_d;
      key_q    <= key_d;
      mpos_q   <= mpos_d;
    end
  end

  always_comb begin
    res_o = res;
    if (!take_i) res_o.count = 2'd0;
  end

endmodule

### rtl/wsd_out_fifo.sv
// Four-entry result queue, takes up to two results and gives one per cycle while not stalled.
// Depends on wsd_pkg for the result types.
module wsd_out_fifo import wsd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  result_pair_t push_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         stall_i,
  output result_t      head_o
);

  result_t    mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign full_o  = (count_q > 3'd2);
  assign pop     = valid_o && !stall_i;
  assign head_o  = mem_q[rptr_q];
  assign count_d = count_q + {1'b0, push_i.count} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wptr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wptr_q + 2'd1] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + push_i.count;
      rptr_q  <= rptr_q + {1'b0, pop};
      count_q <= count_d;
    end
  end

endmodule

### rtl/websocket_frame_deframer.sv
// Receive-side websocket deframer for one connection: takes one stream byte per
// transfer and offers its results from a four-entry queue that registers them.
// Every byte is parsed combinationally, so the block sustains one byte per
// cycle; a ping header byte yields two results, and the input stalls while
// fewer than two queue slots are free, so only an output that is slower than
// one result per cycle slows it down.
// After a close frame the block ignores all bytes until reset.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  result_pair_t res;
  result_t      head;
  logic         full;
  logic         take;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_byte_i),
    .res_o  (res)
  );

  wsd_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign out_kind_o = head.kind;
  assign out_byte_o = head.data;
  assign out_last_o = head.last;

endmodule

### rtl/wsd_checker.sv
// Port-level checks of the websocket deframer and the bind that attaches them.
// Depends on wsd_pkg for the result kind codes.
module wsd_checker import wsd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o)
      && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled result changed");

  a_close_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KindClose |-> out_last_o && out_byte_o == 8'h00)
    else $error("malformed close result");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KindEmpty |-> out_last_o && out_byte_o == 8'h00)
    else $error("malformed empty text result");

  a_close_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_kind_o == KindClose |=> !out_valid_o)
    else $error("result after close");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_byte_i   (in_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_kind_o  (out_kind_o),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

### tb/tb_websocket_frame_deframer.sv
// Testbench for websocket_frame_deframer: drives frames byte by byte and checks every
// result against a built-in parser model held in a small scoreboard class.
// Depends on rtl/wsd_pkg.sv and rtl/websocket_frame_deframer.sv.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhExt, PhMask, PhData, PhClosed
  } parse_phase_e;

  typedef enum int {FormShort, Form16, Form64} len_form_e;

  class frame_scoreboard;
    parse_phase_e ph;
    logic [3:0]   opcode;
    logic         masked;
    logic [63:0]  remaining;
    logic [2:0]   hdr_left;
    logic [31:0]  key;
    logic [1:0]   key_idx;
    result_t      expected_q[$];
    int unsigned  mismatches;

    function new();
      ph = PhHdr0;
      opcode = '0;
      masked = 1'b0;
      remaining = '0;
      hdr_left = '0;
      key = '0;
      key_idx = '0;
      mismatches = 0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic last);
      result_t r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      expected_q = {expected_q, r};
    endfunction

    function void start_payload();
      logic empty;
      empty = (remaining == 64'd0);
      key_idx = 2'd0;
      if (opcode == OpcPing) begin
        push(KindPong, PongHdr, 1'b0);
        push(KindPong, {1'b0, remaining[6:0]}, empty);
      end else if (empty && opcode == OpcText) begin
        push(KindEmpty, 8'h00, 1'b1);
      end else if (empty && opcode == OpcClose) begin
        push(KindClose, 8'h00, 1'b1);
        ph = PhClosed;
        return;
      end
      ph = empty ? PhHdr0 : PhData;
    endfunction

    function void length_done();
      if (masked) begin
        key = '0;
        hdr_left = 3'd3;
        ph = PhMask;
      end else begin
        start_payload();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] plain;
      logic       fin;
      case (ph)
        PhClosed: ;
        PhHdr1: begin
          masked = b[7];
          remaining = '0;
          if (b[6:0] == Len16Code) begin
            hdr_left = 3'd1;
            ph = PhExt;
          end else if (b[6:0] == Len64Code) begin
            hdr_left = 3'd7;
            ph = PhExt;
          end else begin
            remaining = {57'd0, b[6:0]};
            length_done();
          end
        end
        PhExt: begin
          remaining = {remaining[55:0], b};
          if (hdr_left == 3'd0) length_done();
          else hdr_left--;
        end
        PhMask: begin
          key = {key[23:0], b};
          if (hdr_left == 3'd0) start_payload();
          else hdr_left--;
        end
        PhData: begin
          plain = b ^ (masked ? key[8 * (3 - key_idx) +: 8] : 8'h00);
          key_idx++;
          remaining--;
          fin = (remaining == 64'd0);
          if (opcode == OpcText) begin
            push(KindText, plain, fin);
          end else if (opcode == OpcPing) begin
            push(KindPong, plain, fin);
          end else if (opcode == OpcClose && fin) begin
            push(KindClose, 8'h00, 1'b1);
            ph = PhClosed;
          end
          if (fin && ph != PhClosed) ph = PhHdr0;
        end
        default: begin
          opcode = b[3:0];
          ph = PhHdr1;
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d byte %02h last %0b", kind, data, last));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last)
        flag({$sformatf("result: expected kind %0d byte %02h last %0b",
                        want.kind, want.data, want.last),
              $sformatf(", got kind %0d byte %02h last %0b", kind, data, last)});
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit all_matched();
      if (expected_q.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_q.size()));
      return mismatches == 0;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  frame_scoreboard scb;
  logic [7:0]      stim_q[$];
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  bit              long_hold_req;

  websocket_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void queue_byte(logic [7:0] b);
    stim_q = {stim_q, b};
  endfunction

  task automatic push_frame(logic [7:0] hdr0, logic mask_on, logic [63:0] len,
                            len_form_e form, logic [31:0] mkey);
    queue_byte(hdr0);
    case (form)
      Form16: begin
        queue_byte({mask_on, Len16Code});
        queue_byte(len[15:8]);
        queue_byte(len[7:0]);
      end
      Form64: begin
        queue_byte({mask_on, Len64Code});
        for (int i = 7; i >= 0; i--) queue_byte(len[8 * i +: 8]);
      end
      default: queue_byte({mask_on, len[6:0]});
    endcase
    if (mask_on) for (int i = 3; i >= 0; i--) queue_byte(mkey[8 * i +: 8]);
    repeat (len) queue_byte(8'($urandom));
  endtask

  task automatic push_random_frame();
    logic [3:0]  opc;
    int unsigned roll;
    int unsigned len;
    len_form_e   form;
    roll = $urandom_range(99);
    if (roll < 45) begin
      opc = OpcText;
    end else if (roll < 75) begin
      opc = OpcPing;
    end else begin
      do opc = 4'($urandom); while (opc == OpcText || opc == OpcClose || opc == OpcPing);
    end
    if ($urandom_range(99) < 2) len = $urandom_range(200, 120);
    else len = $urandom_range(12);
    roll = $urandom_range(99);
    if (len > 125) form = Form16;
    else if (roll < 70) form = FormShort;
    else if (roll < 90) form = Form16;
    else form = Form64;
    push_frame({4'($urandom), opc}, $urandom_range(99) < 70, len, form, $urandom);
  endtask

  // Offer queued bytes; hold each one until its transfer.
  task automatic drive_bytes();
    while (stim_q.size() > 0) begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid_i = 1'b0;
        in_byte_i = 8'($urandom);
      end else begin
        in_valid_i = 1'b1;
        in_byte_i = stim_q[0];
        do @(posedge clk_i); while (in_stall_o);
        scb.note_byte(stim_q.pop_front());
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) scb.check_result(out_kind_o, out_byte_o, out_last_o);
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    scb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = 8'h00;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_frame(8'h81, 1'b0, 0, FormShort, '0);
    push_frame(8'h09, 1'b0, 0, FormShort, '0);
    push_frame(8'h81, 1'b1, 2, FormShort, 32'hFF00A55A);
    push_frame(8'hF9, 1'b0, 1, Form16, '0);
    push_frame(8'hFF, 1'b1, 1, FormShort, 32'hFFFFFFFF);
    push_frame(8'h01, 1'b0, 0, Form64, '0);
    drive_bytes();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  long_hold_req = 1'b1; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      while (stim_q.size() < 275) push_random_frame();
      drive_bytes();
    end

    // Close ends the stream; the trailing bytes must be dropped.
    send_idle_pct = 10;
    recv_stall_pct = 10;
    push_frame({4'($urandom), OpcClose}, 1'($urandom),
               $urandom_range(1) ? 0 : $urandom_range(5, 1), FormShort, $urandom);
    repeat (4) queue_byte(8'($urandom));
    drive_bytes();

    while (scb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (scb.all_matched()) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_out_fifo.sv
rtl/websocket_frame_deframer.sv
rtl/wsd_checker.sv
tb/tb_websocket_frame_deframer.sv
